[rtl/srg_pkg.sv]
// Package for the stepper ramp generator: widths, codes and shared types.
// Used by the channel interfaces, the serial divider and the top level.
package srg_pkg;

    localparam int POSITION_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF     = 32;

    localparam int OP_WIDTH        = 3;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int ACCEL_WIDTH     = 16;
    localparam int INTERVAL_WIDTH  = 32;
    localparam int FRAC_BITS       = 8;
    localparam int SPEED_WIDTH     = INTERVAL_WIDTH - FRAC_BITS;
    localparam int RAMP_WIDTH      = 32;
    localparam int STS_WIDTH       = 31;

    localparam int DIV_NUM_WIDTH   = 56;
    localparam int DIV_DEN_WIDTH   = INTERVAL_WIDTH + 2;
    localparam int DIV_COUNT_WIDTH = $clog2(DIV_NUM_WIDTH);

    localparam logic [DIV_NUM_WIDTH-1:0] STOP_NUM = 56'd32768000000000000;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_TICK     = 3'd0,
        OP_MOVE_ABS = 3'd1,
        OP_MOVE_REL = 3'd2,
        OP_SET_POS  = 3'd3,
        OP_STOP     = 3'd4
    } op_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ACCEL = 2'd0,
        CFG_FIRST = 2'd1,
        CFG_MIN   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                     start;
        logic [DIV_NUM_WIDTH-1:0] dividend;
        logic [DIV_DEN_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [DIV_NUM_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/srg_if.sv]
// Valid/ready channel interfaces of the stepper ramp generator.
// Depends on srg_pkg for the field widths.
interface srg_in_if
    import srg_pkg::*;
#(
    parameter int PW = POSITION_WIDTH_DEF,
    parameter int TW = TIME_WIDTH_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [OP_WIDTH-1:0]  operation;
    logic [TW-1:0]        now_us;
    logic signed [PW-1:0] position_value;

    modport source (output valid, operation, now_us, position_value, input ready);
    modport sink (input valid, operation, now_us, position_value, output ready);
endinterface

interface srg_out_if
    import srg_pkg::*;
#(
    parameter int PW = POSITION_WIDTH_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic                 step_pulse;
    logic                 step_direction;
    logic signed [PW-1:0] current_position;
    logic signed [PW-1:0] remaining_distance;
    logic                 moving;

    modport source (output valid, step_pulse, step_direction, current_position,
                    remaining_distance, moving, input ready);
    modport sink (input valid, step_pulse, step_direction, current_position,
                  remaining_distance, moving, output ready);
endinterface

interface srg_cfg_if
    import srg_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] reg_index;
    logic [CFG_DATA_WIDTH-1:0]  wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

[rtl/srg_divider.sv]
// Bit-serial restoring divider, one quotient bit per clock.
// Depends on srg_pkg for the request and response structs.
module srg_divider
    import srg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [DIV_COUNT_WIDTH-1:0] LAST_COUNT = DIV_COUNT_WIDTH'(DIV_NUM_WIDTH - 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [DIV_COUNT_WIDTH-1:0] count_reg;
    logic [DIV_DEN_WIDTH-1:0]   rem_reg;
    logic [DIV_NUM_WIDTH-1:0]   quo_reg;
    logic [DIV_DEN_WIDTH-1:0]   den_reg;

    logic [DIV_DEN_WIDTH:0]     shifted;
    logic [DIV_DEN_WIDTH:0]     diff;
    logic                       fits;

    assign shifted = {rem_reg, quo_reg[DIV_NUM_WIDTH-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == LAST_COUNT)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_DEN_WIDTH-1:0] : shifted[DIV_DEN_WIDTH-1:0];
            quo_reg <= {quo_reg[DIV_NUM_WIDTH-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/stepper_ramp_generator.sv]
// Top level of the stepper ramp generator: sequencer, state and result register.
// Depends on srg_pkg, the channel interfaces in srg_if and srg_divider.
//
// Each request is a timer tick or a motion command and yields one result. New speed
// calculations run through one shared bit-serial divider: three quotients for the
// stopping distance and one for the ramp update. A stop command can run the
// stopping distance calculation a second time for its new target.
// The result waits in an output register while the next request is taken in.
module stepper_ramp_generator
    import srg_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int TIME_WIDTH     = TIME_WIDTH_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    srg_cfg_if.sink    cfg,
    srg_in_if.sink     in_req,
    srg_out_if.source  out_res
);

    localparam int PW    = POSITION_WIDTH;
    localparam int TW    = TIME_WIDTH;
    localparam int CMP_W = PW + STS_WIDTH;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_EXEC   = 9'b000000010,
        S_STS    = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_STOPMV = 9'b000010000,
        S_DECIDE = 9'b000100000,
        S_RAMP   = 9'b001000000,
        S_APPLY  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        K_STS1 = 2'd0,
        K_STS2 = 2'd1,
        K_STS3 = 2'd2,
        K_RAMP = 2'd3
    } div_kind_t;

    state_t                     state_reg, state_next;
    div_kind_t                  kind_reg, kind_next;
    logic [OP_WIDTH-1:0]        op_reg, op_next;
    logic [TW-1:0]              now_reg, now_next;
    logic [PW-1:0]              val_reg, val_next;

    logic [ACCEL_WIDTH-1:0]     acc_reg;
    logic [INTERVAL_WIDTH-1:0]  first_reg;
    logic [INTERVAL_WIDTH-1:0]  min_reg;

    logic [PW-1:0]              pos_reg, pos_next;
    logic [PW-1:0]              tgt_reg, tgt_next;
    logic [RAMP_WIDTH-1:0]      ri_reg, ri_next;
    logic [INTERVAL_WIDTH-1:0]  ifx_reg, ifx_next;
    logic [SPEED_WIDTH-1:0]     siu_reg, siu_next;
    logic [TW-1:0]              last_reg, last_next;
    logic                       dir_reg, dir_next;
    logic [STS_WIDTH-1:0]       sts_reg, sts_next;
    logic                       pulse_reg, pulse_next;
    logic                       stop_phase_reg, stop_phase_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_pulse_reg;
    logic                       out_dir_reg;
    logic [PW-1:0]              out_pos_reg;
    logic [PW-1:0]              out_dist_reg;
    logic                       out_moving_reg;
    logic                       out_load;

    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    logic [PW-1:0]              delta;
    logic                       dist_neg;
    logic                       dist_nz;
    logic [PW-1:0]              mag;
    logic                       sts_ge_mag;
    logic                       ri_pos;
    logic                       ri_neg;
    logic [TW-1:0]              next_t;
    logic                       due;
    logic [PW-1:0]              step_pos;
    logic [ACCEL_WIDTH-1:0]     acc_eff;
    logic [STS_WIDTH-1:0]       q_sat;
    logic [RAMP_WIDTH-1:0]      ri_mag;
    logic [DIV_DEN_WIDTH-1:0]   ramp_den;
    logic [INTERVAL_WIDTH:0]    cn_sub;
    logic [INTERVAL_WIDTH:0]    cn_add;
    logic [INTERVAL_WIDTH-1:0]  cn_sat;
    logic [INTERVAL_WIDTH-1:0]  cn_clamp;
    logic [STS_WIDTH:0]         stop_len;
    logic [PW-1:0]              stop_len_pw;
    logic [PW-1:0]              stop_tgt;
    logic [PW-1:0]              rel_tgt;

    srg_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= ACCEL_WIDTH'(1);
            first_reg <= '0;
            min_reg   <= INTERVAL_WIDTH'(256);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                CFG_ACCEL: acc_reg   <= cfg.wdata[ACCEL_WIDTH-1:0];
                CFG_FIRST: first_reg <= cfg.wdata[INTERVAL_WIDTH-1:0];
                CFG_MIN:   min_reg   <= cfg.wdata[INTERVAL_WIDTH-1:0];
                default:   ;
            endcase
        end
    end

    assign delta      = tgt_reg - pos_reg;
    assign dist_neg   = delta[PW-1];
    assign dist_nz    = |delta;
    assign mag        = dist_neg ? (PW'(0) - delta) : delta;
    assign sts_ge_mag = CMP_W'(sts_reg) >= CMP_W'(mag);
    assign ri_pos     = (|ri_reg) && !ri_reg[RAMP_WIDTH-1];
    assign ri_neg     = ri_reg[RAMP_WIDTH-1];

    assign next_t   = last_reg + TW'(siu_reg);
    assign due      = (next_t >= last_reg) ? ((now_reg >= next_t) || (now_reg < last_reg))
                                           : ((now_reg >= next_t) && (now_reg < last_reg));
    assign step_pos = dir_reg ? (pos_reg + PW'(1)) : (pos_reg - PW'(1));

    assign acc_eff  = (acc_reg == '0) ? ACCEL_WIDTH'(1) : acc_reg;
    assign q_sat    = (|div_rsp.quotient[DIV_NUM_WIDTH-1:STS_WIDTH]) ? '1
                                                             : div_rsp.quotient[STS_WIDTH-1:0];

    assign ri_mag   = RAMP_WIDTH'(0) - ri_reg;
    assign ramp_den = ri_neg ? ({ri_mag, 2'b00} - DIV_DEN_WIDTH'(1)) : {ri_reg, 2'b01};

    assign cn_sub   = {1'b0, ifx_reg} - div_rsp.quotient[INTERVAL_WIDTH:0];
    assign cn_add   = {1'b0, ifx_reg} + div_rsp.quotient[INTERVAL_WIDTH:0];
    assign cn_sat   = ri_neg ? (cn_add[INTERVAL_WIDTH] ? '1 : cn_add[INTERVAL_WIDTH-1:0])
                             : cn_sub[INTERVAL_WIDTH-1:0];
    assign cn_clamp = (cn_sat < min_reg) ? min_reg : cn_sat;

    assign stop_len    = {1'b0, sts_reg} + (STS_WIDTH + 1)'(1);
    assign stop_len_pw = PW'(stop_len);
    assign stop_tgt    = dir_reg ? (pos_reg + stop_len_pw) : (pos_reg - stop_len_pw);
    assign rel_tgt     = pos_reg + val_reg;

    assign in_req.ready = (state_reg == S_IDLE);
    assign out_load     = (state_reg == S_FINISH) && (!out_valid_reg || out_res.ready);

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        tgt_next        = tgt_reg;
        ri_next         = ri_reg;
        ifx_next        = ifx_reg;
        siu_next        = siu_reg;
        last_next       = last_reg;
        dir_next        = dir_reg;
        sts_next        = sts_reg;
        pulse_next      = pulse_reg;
        stop_phase_next = stop_phase_reg;
        div_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_req.valid)
                begin
                    op_next    = in_req.operation;
                    now_next   = in_req.now_us;
                    val_next   = in_req.position_value;
                    pulse_next = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next      = S_FINISH;
                stop_phase_next = 1'b0;
                unique case (op_reg)
                    OP_TICK:
                    begin
                        if ((siu_reg != '0) && due)
                        begin
                            pos_next   = step_pos;
                            last_next  = now_reg;
                            pulse_next = 1'b1;
                            state_next = S_STS;
                        end
                    end
                    OP_MOVE_ABS:
                    begin
                        if (tgt_reg != val_reg)
                        begin
                            tgt_next   = val_reg;
                            state_next = S_STS;
                        end
                    end
                    OP_MOVE_REL:
                    begin
                        if (tgt_reg != rel_tgt)
                        begin
                            tgt_next   = rel_tgt;
                            state_next = S_STS;
                        end
                    end
                    OP_SET_POS:
                    begin
                        pos_next = val_reg;
                        tgt_next = val_reg;
                        ri_next  = '0;
                        siu_next = '0;
                    end
                    OP_STOP:
                    begin
                        if ((siu_reg != '0) && (ifx_reg != '0))
                        begin
                            stop_phase_next = 1'b1;
                            state_next      = S_STS;
                        end
                    end
                    default: ;
                endcase
            end
            S_STS:
            begin
                if ((siu_reg == '0) || (ifx_reg == '0))
                begin
                    sts_next   = '0;
                    state_next = stop_phase_reg ? S_STOPMV : S_DECIDE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = STOP_NUM;
                    div_req.divisor  = DIV_DEN_WIDTH'(ifx_reg);
                    kind_next        = K_STS1;
                    state_next       = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    unique case (kind_reg)
                        K_STS1:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = div_rsp.quotient;
                            div_req.divisor  = DIV_DEN_WIDTH'(ifx_reg);
                            kind_next        = K_STS2;
                        end
                        K_STS2:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = div_rsp.quotient;
                            div_req.divisor  = DIV_DEN_WIDTH'(acc_eff);
                            kind_next        = K_STS3;
                        end
                        K_STS3:
                        begin
                            sts_next   = q_sat;
                            state_next = stop_phase_reg ? S_STOPMV : S_DECIDE;
                        end
                        K_RAMP:
                        begin
                            state_next = S_APPLY;
                        end
                        default: ;
                    endcase
                end
            end
            S_STOPMV:
            begin
                state_next = S_FINISH;
                if (tgt_reg != stop_tgt)
                begin
                    tgt_next        = stop_tgt;
                    stop_phase_next = 1'b0;
                    state_next      = S_STS;
                end
            end
            S_DECIDE:
            begin
                if (!dist_nz && (sts_reg <= STS_WIDTH'(1)))
                begin
                    siu_next   = '0;
                    ri_next    = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    if (dist_nz)
                    begin
                        if (ri_pos && (sts_ge_mag || (dir_reg != !dist_neg)))
                        begin
                            ri_next = RAMP_WIDTH'(0) - RAMP_WIDTH'(sts_reg);
                        end
                        else if (ri_neg && !sts_ge_mag && (dir_reg == !dist_neg))
                        begin
                            ri_next = ri_mag;
                        end
                    end
                    state_next = S_RAMP;
                end
            end
            S_RAMP:
            begin
                if (ri_reg == '0)
                begin
                    ifx_next   = first_reg;
                    dir_next   = dist_nz && !dist_neg;
                    ri_next    = RAMP_WIDTH'(1);
                    siu_next   = first_reg[INTERVAL_WIDTH-1:FRAC_BITS];
                    state_next = S_FINISH;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_NUM_WIDTH'({ifx_reg, 1'b0});
                    div_req.divisor  = ramp_den;
                    kind_next        = K_RAMP;
                    state_next       = S_DIV;
                end
            end
            S_APPLY:
            begin
                ifx_next   = cn_clamp;
                ri_next    = ri_reg + RAMP_WIDTH'(1);
                siu_next   = cn_clamp[INTERVAL_WIDTH-1:FRAC_BITS];
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= K_STS1;
            pos_reg        <= '0;
            tgt_reg        <= '0;
            ri_reg         <= '0;
            ifx_reg        <= '0;
            siu_reg        <= '0;
            last_reg       <= '0;
            dir_reg        <= 1'b0;
            sts_reg        <= '0;
            pulse_reg      <= 1'b0;
            stop_phase_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            pos_reg        <= pos_next;
            tgt_reg        <= tgt_next;
            ri_reg         <= ri_next;
            ifx_reg        <= ifx_next;
            siu_reg        <= siu_next;
            last_reg       <= last_next;
            dir_reg        <= dir_next;
            sts_reg        <= sts_next;
            pulse_reg      <= pulse_next;
            stop_phase_reg <= stop_phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_res.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        now_reg <= now_next;
        val_reg <= val_next;
        if (out_load)
        begin
            out_pulse_reg  <= pulse_reg;
            out_dir_reg    <= dir_reg;
            out_pos_reg    <= pos_reg;
            out_dist_reg   <= delta;
            out_moving_reg <= (siu_reg != '0);
        end
    end

    assign out_res.valid              = out_valid_reg;
    assign out_res.step_pulse         = out_pulse_reg;
    assign out_res.step_direction     = out_dir_reg;
    assign out_res.current_position   = out_pos_reg;
    assign out_res.remaining_distance = out_dist_reg;
    assign out_res.moving             = out_moving_reg;

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("Divider started while a division is running.");

    a_div_wait_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_rsp.busy || div_rsp.done))
        else $error("Sequencer waits on a divider that is not running.");

    a_interval_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |=> (ifx_reg >= min_reg))
        else $error("Ramp update left the interval below the minimum.");
`endif

endmodule

[bench/tb.sv]
// Testbench for stepper_ramp_generator: directed and random tick and motion requests.
// Depends on srg_pkg, the channel interfaces in srg_if and the block's RTL.
// A scoreboard class predicts every result and compares it field by field.
module tb;
    import srg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;
    localparam logic [OP_WIDTH-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_WIDTH-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_SPARE_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        pulse;
        logic        dir;
        logic [31:0] pos;
        logic [31:0] rem;
        logic        moving;
    } ramp_result_t;

    class ramp_scoreboard;
        logic [31:0]  accel;
        logic [31:0]  first_iv;
        logic [31:0]  min_iv;
        logic [31:0]  pos;
        logic [31:0]  tgt;
        logic [31:0]  ramp_n;
        logic [31:0]  iv_fixed;
        logic [31:0]  step_us;
        logic [31:0]  last_t;
        logic         cw;
        ramp_result_t pending[$];
        int           mismatches;
        int           checked;
        int           steps_seen;

        function new();
            accel = 1;
            first_iv = 0;
            min_iv = 256;
            pos = 0;
            tgt = 0;
            ramp_n = 0;
            iv_fixed = 0;
            step_us = 0;
            last_t = 0;
            cw = 0;
            mismatches = 0;
            checked = 0;
            steps_seen = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] data);
            if (idx == CFG_ACCEL)
                accel = {16'd0, data[15:0]};
            else if (idx == CFG_FIRST)
                first_iv = data;
            else if (idx == CFG_MIN)
                min_iv = data;
        endfunction

        function logic [63:0] stop_distance();
            logic [63:0] q;
            logic [63:0] a;
            a = (accel == 0) ? 64'd1 : {32'd0, accel};
            if (step_us == 0 || iv_fixed == 0)
                return 64'd0;
            q = 64'd32768000000000000 / {32'd0, iv_fixed};
            q = q / {32'd0, iv_fixed};
            q = q / a;
            return (q > 64'h7FFFFFFF) ? 64'h7FFFFFFF : q;
        endfunction

        function void update_speed();
            logic [31:0] d;
            logic [31:0] dneg;
            logic        neg;
            logic [63:0] mag;
            logic [63:0] sts;
            logic        npos;
            logic        nneg;
            logic [63:0] cn;
            logic [63:0] m;
            logic [31:0] mneg;
            d = tgt - pos;
            neg = d[31];
            dneg = 32'd0 - d;
            mag = neg ? {32'd0, dneg} : {32'd0, d};
            sts = stop_distance();
            npos = (ramp_n != 0) && !ramp_n[31];
            nneg = ramp_n[31];
            if (d == 0 && sts <= 1) begin
                step_us = 0;
                ramp_n = 0;
                return;
            end
            if (d != 0) begin
                if (npos) begin
                    if (sts >= mag || cw != !neg)
                        ramp_n = 32'd0 - sts[31:0];
                end else if (nneg) begin
                    if (sts < mag && cw == !neg)
                        ramp_n = 32'd0 - ramp_n;
                end
            end
            if (ramp_n == 0) begin
                iv_fixed = first_iv;
                cw = (d != 0) && !neg;
            end else begin
                cn = {32'd0, iv_fixed};
                if (!ramp_n[31]) begin
                    cn = cn - (2 * cn) / (4 * {32'd0, ramp_n} + 1);
                end else begin
                    mneg = 32'd0 - ramp_n;
                    m = (mneg == 0) ? 64'h80000000 : {32'd0, mneg};
                    cn = cn + (2 * cn) / (4 * m - 1);
                    if (cn > 64'hFFFFFFFF)
                        cn = 64'hFFFFFFFF;
                end
                if (cn < {32'd0, min_iv})
                    cn = {32'd0, min_iv};
                iv_fixed = cn[31:0];
            end
            ramp_n = ramp_n + 1;
            step_us = {8'd0, iv_fixed[31:8]};
        endfunction

        function void set_target(logic [31:0] t);
            if (tgt != t) begin
                tgt = t;
                update_speed();
            end
        endfunction

        function logic tick_due(logic [31:0] now);
            logic [31:0] nxt;
            logic        due;
            if (step_us == 0)
                return 1'b0;
            nxt = last_t + step_us;
            if (nxt >= last_t)
                due = (now >= nxt) || (now < last_t);
            else
                due = (now >= nxt) && (now < last_t);
            if (!due)
                return 1'b0;
            pos = cw ? pos + 1 : pos - 1;
            last_t = now;
            return 1'b1;
        endfunction

        function void note_request(logic [OP_WIDTH-1:0] op, logic [31:0] now,
                                   logic [31:0] val);
            ramp_result_t r;
            logic [63:0]  s;
            r.pulse = 1'b0;
            case (op)
                OP_TICK:
                    if (tick_due(now)) begin
                        r.pulse = 1'b1;
                        steps_seen++;
                        update_speed();
                    end
                OP_MOVE_ABS: set_target(val);
                OP_MOVE_REL: set_target(pos + val);
                OP_SET_POS:
                begin
                    pos = val;
                    tgt = val;
                    ramp_n = 0;
                    step_us = 0;
                end
                OP_STOP:
                    if (step_us != 0 && iv_fixed != 0) begin
                        s = stop_distance() + 1;
                        set_target(cw ? pos + s[31:0] : pos - s[31:0]);
                    end
                default: ;
            endcase
            r.dir = cw;
            r.pos = pos;
            r.rem = tgt - pos;
            r.moving = (step_us != 0);
            pending.push_back(r);
        endfunction

        function void check_result(ramp_result_t got);
            ramp_result_t exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: %p", got);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got.pulse !== exp_r.pulse || got.dir !== exp_r.dir || got.pos !== exp_r.pos
                || got.rem !== exp_r.rem || got.moving !== exp_r.moving) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch on result %0d: expected pulse %b dir %b pos %0d rem %0d moving %b",
                             checked, exp_r.pulse, exp_r.dir, $signed(exp_r.pos),
                             $signed(exp_r.rem), exp_r.moving);
                    $display("    actual pulse %b dir %b pos %0d rem %0d moving %b",
                             got.pulse, got.dir, $signed(got.pos), $signed(got.rem),
                             got.moving);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cycles;
    int   quiet_cycles;
    logic [31:0] now_clock;
    ramp_scoreboard sb;

    srg_cfg_if cfg_ch ();
    srg_in_if  req_ch ();
    srg_out_if res_ch ();

    stepper_ramp_generator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch.sink),
        .in_req  (req_ch.sink),
        .out_res (res_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.operation = '0;
        req_ch.now_us = '0;
        req_ch.position_value = '0;
        res_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        ramp_result_t got;
        if (res_ch.valid && res_ch.ready) begin
            got.pulse = res_ch.step_pulse;
            got.dir = res_ch.step_direction;
            got.pos = res_ch.current_position;
            got.rem = res_ch.remaining_distance;
            got.moving = res_ch.moving;
            sb.check_result(got);
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_cfg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic end_cfg();
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(logic [OP_WIDTH-1:0] op, logic [31:0] now,
                                logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.now_us <= now;
        req_ch.position_value <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(op, now, val);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_tick();
        int unsigned span;
        span = (sb.step_us > 50000) ? 100000 : 2 * sb.step_us + 4;
        if ($urandom_range(99) < 3)
            now_clock = $urandom;
        else
            now_clock = now_clock + $urandom_range(span);
        send_request(OP_TICK, now_clock, $urandom);
    endtask

    task automatic send_random();
        int unsigned pick;
        logic [31:0] val;
        pick = $urandom_range(99);
        val = ($urandom_range(9) == 0) ? $urandom : $urandom_range(80) - 40;
        if (pick < 62)
            send_tick();
        else if (pick < 77)
            send_request(OP_MOVE_REL, $urandom, val);
        else if (pick < 85)
            send_request(OP_MOVE_ABS, $urandom, sb.pos + val);
        else if (pick < 90)
            send_request(OP_SET_POS, $urandom, ($urandom_range(3) == 0) ? $urandom : val);
        else if (pick < 96)
            send_request(OP_STOP, $urandom, $urandom);
        else
            send_request(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), $urandom, $urandom);
    endtask

    task automatic run_directed();
        send_request(OP_SET_POS, 32'd0, 32'h7FFFFFFF);
        send_request(OP_MOVE_REL, 32'd0, 32'd1);
        repeat (4) send_tick();
        send_request(OP_SET_POS, 32'd0, 32'h80000000);
        send_request(OP_MOVE_ABS, 32'd0, 32'd0);
        repeat (3) send_tick();
        send_request(OP_STOP, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_request(OP_TICK, 32'hFFFFFFFF, 32'd0);
        send_request(OP_TICK, 32'd0, 32'd0);
        send_request(OP_SPARE_LO, 32'hFFFFFFFF, 32'h80000000);
        send_request(OP_SPARE_MID, 32'd0, 32'd5);
        send_request(OP_SPARE_HI, 32'd1, 32'hFFFFFFFF);
        send_request(OP_MOVE_REL, 32'd0, 32'hFFFFFFF0);
        repeat (5) send_tick();
        send_request(OP_STOP, 32'd0, 32'd0);
        repeat (3) send_tick();
        send_request(OP_SET_POS, 32'hFFFFFFFF, 32'd0);
    endtask

    initial
    begin
        logic [31:0] accel_set[6] = '{32'd1, 32'd65535, 32'd1000, 32'd0, 32'd300, 32'd65535};
        logic [31:0] first_set[6] = '{32'd12800, 32'd25600, 32'd100, 32'hFFFFFFFF,
                                      32'd5000, 32'd2560};
        logic [31:0] min_set[6] = '{32'd256, 32'd1, 32'd256, 32'hFFFFFFFF,
                                    32'd2560, 32'd1};
        int idle_set[4] = '{0, 59, 0, 38};
        int stall_set[4] = '{0, 0, 59, 38};
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        now_clock = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain();
        write_cfg(CFG_UNUSED, 32'hFFFFFFFF);
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(CFG_ACCEL, accel_set[ph]);
            write_cfg(CFG_FIRST, first_set[ph]);
            write_cfg(CFG_MIN, min_set[ph]);
            end_cfg();
            if (ph == 0)
                run_directed();
            for (int k = 0; k < 4; k++) begin
                send_idle_pct = idle_set[k];
                recv_stall_pct = stall_set[k];
                if (ph == 1 && k == 0)
                    hold_cycles = 400;
                repeat (60) send_random();
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        $display("Checked %0d results covering %0d steps over six register settings.",
                 sb.checked, sb.steps_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
